FILE: design/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: default geometry,
// control codes, action codes and sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS_DEF = 8;
  localparam int ROWS_DEF = 14;

  localparam logic [7:0] CODE_CR    = 8'h0D;
  localparam logic [7:0] CODE_NL    = 8'h0A;
  localparam logic [7:0] CODE_SPACE = 8'h20;
  localparam logic [7:0] CODE_MAX   = 8'h97;
  localparam logic [7:0] COLOUR_MAX = 8'd63;

  typedef enum logic [2:0] {
    ACT_STREAM = 3'd0,
    ACT_PUT    = 3'd1,
    ACT_SETCUR = 3'd2,
    ACT_SETCOL = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDWAIT,
    ST_MOVE,
    ST_LAST,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

FILE: design/tcw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Character screen of ROWS x COLS cells with a cursor and per-row colours.
// Each accepted word ends in a response state; a read first waits on the
// memory, and a scroll or a shift at the final cell first runs a copy pass.
// Throughput: one word at a time; bulk moves copy one cell per cycle through
// the single write port of the screen memory.
// Reset: cursor to 0, then a clearing pass fills spaces and zero colours,
// during which no word is accepted.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] action,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] col,
  input  wire logic [7:0] row,
  input  wire logic [7:0] colour,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            status,
  output logic [7:0]      cell_char,
  output logic [5:0]      cell_colour,
  output logic [2:0]      cur_col,
  output logic [3:0]      cur_row
);

  localparam int CELLS = COLS * ROWS;
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam logic [7:0]      COLS_B     = 8'(COLS);
  localparam logic [7:0]      ROWS_B     = 8'(ROWS);
  localparam logic [CNTW-1:0] SCROLL_LEN = CNTW'(COLS * (ROWS - 1));
  localparam logic [CNTW-1:0] SHIFT_LEN  = CNTW'(CELLS - 1);
  localparam logic [CNTW-1:0] CLEAR_END  = CNTW'(CELLS - 1);

  state_t          state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic [CNTW-1:0] mv_len, mv_len_next;
  logic [AW-1:0]   mv_off, mv_off_next;
  logic            mv_last, mv_last_next;
  logic [7:0]      chr, chr_next;
  logic [CW-1:0]   cursor_col, cursor_col_next;
  logic [RW-1:0]   cursor_row, cursor_row_next;
  logic            res_status, res_status_next;
  logic [7:0]      res_char, res_char_next;
  logic [5:0]      res_colour, res_colour_next;
  logic            out_valid_next;

  logic            scr_we;
  logic [AW-1:0]   scr_waddr, scr_raddr;
  logic [7:0]      scr_wdata, scr_rdata;
  logic            pal_we;
  logic [RW-1:0]   pal_waddr, pal_raddr;
  logic [5:0]      pal_wdata, pal_rdata;

  logic            in_range;
  logic            at_final;
  logic [CW-1:0]   cell_col;
  logic [RW-1:0]   cell_row;
  logic [AW-1:0]   cell_addr;

  tcw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_screen (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  tcw_ram #(.WIDTH(6), .DEPTH(ROWS)) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  assign in_range = (col < COLS_B) && (row < ROWS_B);
  assign at_final = (cursor_col == CW'(COLS - 1)) && (cursor_row == RW'(ROWS - 1));

  // stream put addresses the cursor, everything else the input coordinates
  assign cell_col  = (action == ACT_STREAM) ? cursor_col : col[CW-1:0];
  assign cell_row  = (action == ACT_STREAM) ? cursor_row : row[RW-1:0];
  assign cell_addr = AW'(cell_row) * AW'(COLS) + AW'(cell_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cnt        <= '0;
      cursor_col <= '0;
      cursor_row <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mv_len     <= mv_len_next;
    mv_off     <= mv_off_next;
    mv_last    <= mv_last_next;
    chr        <= chr_next;
    res_status <= res_status_next;
    res_char   <= res_char_next;
    res_colour <= res_colour_next;
    if (state == ST_RESP && (!out_valid || out_ready)) begin
      status      <= res_status;
      cell_char   <= res_char;
      cell_colour <= res_colour;
      cur_col     <= 3'(cursor_col);
      cur_row     <= 4'(cursor_row);
    end
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    mv_len_next     = mv_len;
    mv_off_next     = mv_off;
    mv_last_next    = mv_last;
    chr_next        = chr;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    res_status_next = res_status;
    res_char_next   = res_char;
    res_colour_next = res_colour;
    out_valid_next  = out_valid && !out_ready;
    in_ready        = 1'b0;
    scr_we          = 1'b0;
    scr_waddr       = cell_addr;
    scr_wdata       = char_code;
    scr_raddr       = cell_addr;
    pal_we          = 1'b0;
    pal_waddr       = row[RW-1:0];
    pal_wdata       = colour[5:0];
    pal_raddr       = row[RW-1:0];

    case (state)
      ST_CLEAR: begin
        scr_we    = 1'b1;
        scr_waddr = cnt[AW-1:0];
        scr_wdata = CODE_SPACE;
        pal_we    = (cnt < CNTW'(ROWS));
        pal_waddr = cnt[RW-1:0];
        pal_wdata = '0;
        cnt_next  = cnt + 1'b1;
        if (cnt == CLEAR_END) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          chr_next        = char_code;
          res_status_next = 1'b0;
          res_char_next   = '0;
          res_colour_next = '0;
          cnt_next        = '0;
          mv_last_next    = 1'b0;
          state_next      = ST_RESP;
          case (action)
            ACT_STREAM: begin
              res_char_next = char_code;
              if (char_code == CODE_CR) begin
                cursor_col_next = '0;
              end else if (char_code == CODE_NL) begin
                if (cursor_row != RW'(ROWS - 1)) begin
                  cursor_col_next = '0;
                  cursor_row_next = cursor_row + 1'b1;
                end else begin
                  // scroll up a row, last row stays as it is
                  mv_off_next = AW'(COLS);
                  mv_len_next = SCROLL_LEN;
                  state_next  = ST_MOVE;
                end
              end else if (at_final) begin
                // shift whole screen left one cell, byte lands at the end
                mv_off_next  = AW'(1);
                mv_len_next  = SHIFT_LEN;
                mv_last_next = 1'b1;
                state_next   = ST_MOVE;
              end else begin
                scr_we = 1'b1;
                if (cursor_col == CW'(COLS - 1)) begin
                  cursor_col_next = '0;
                  cursor_row_next = cursor_row + 1'b1;
                end else begin
                  cursor_col_next = cursor_col + 1'b1;
                end
              end
            end
            ACT_PUT: begin
              if (char_code > CODE_MAX || !in_range) begin
                res_status_next = 1'b1;
              end else begin
                scr_we = 1'b1;
              end
            end
            ACT_SETCUR: begin
              if (!in_range) begin
                res_status_next = 1'b1;
              end else begin
                cursor_col_next = col[CW-1:0];
                cursor_row_next = row[RW-1:0];
              end
            end
            ACT_SETCOL: begin
              if (row >= ROWS_B || colour > COLOUR_MAX) begin
                res_status_next = 1'b1;
              end else begin
                pal_we = 1'b1;
              end
            end
            ACT_READ: begin
              if (!in_range) begin
                res_status_next = 1'b1;
              end else begin
                state_next = ST_RDWAIT;
              end
            end
            default: begin
              res_status_next = 1'b1;
            end
          endcase
        end
      end

      ST_RDWAIT: begin
        res_char_next   = scr_rdata;
        res_colour_next = pal_rdata;
        state_next      = ST_RESP;
      end

      ST_MOVE: begin
        // read cell cnt+offset, write the one read last cycle to cnt-1
        scr_raddr = cnt[AW-1:0] + mv_off;
        scr_we    = (cnt != '0);
        scr_waddr = AW'(cnt - 1'b1);
        scr_wdata = scr_rdata;
        cnt_next  = cnt + 1'b1;
        if (cnt == mv_len) begin
          state_next = mv_last ? ST_LAST : ST_RESP;
        end
      end

      ST_LAST: begin
        scr_we     = 1'b1;
        scr_waddr  = AW'(CELLS - 1);
        scr_wdata  = chr;
        state_next = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    (cursor_col <= CW'(COLS - 1)) && (cursor_row <= RW'(ROWS - 1)))
    else $error("cursor outside the screen");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESP)
    else $error("result raised outside the response state");

endmodule
`default_nettype wire

FILE: tb/console_result_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// console_result_checker
// Watches both channels of the text console writer. Keeps its own copy of
// the screen, row colours and cursor, works out the reply to every accepted
// word and compares it with the next reply that leaves the block.
// ----------------------------------------------------------------------------
module console_result_checker
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [2:0] action,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] col,
  input  wire logic [7:0] row,
  input  wire logic [7:0] colour,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic       status,
  input  wire logic [7:0] cell_char,
  input  wire logic [5:0] cell_colour,
  input  wire logic [2:0] cur_col,
  input  wire logic [3:0] cur_row,
  output int              errors,
  output int              pending
);

  localparam int CELLS = COLS * ROWS;

  typedef struct packed {
    logic       rejected;
    logic [7:0] ch;
    logic [5:0] tint;
    logic [2:0] cx;
    logic [3:0] cy;
  } console_reply_t;

  logic [7:0]     screen_mem [CELLS];
  logic [5:0]     row_tint [ROWS];
  logic [2:0]     model_col;
  logic [3:0]     model_row;
  console_reply_t replies_due [$];
  int             fail_total = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // stream put: controls, scroll on the last row, shift at the final cell
  task automatic stream_char(input logic [7:0] c);
    int i;
    if (c == CODE_CR) begin
      model_col = '0;
    end else if (c == CODE_NL) begin
      if (model_row < ROWS - 1) begin
        model_col = '0;
        model_row = model_row + 4'd1;
      end else begin
        for (i = 0; i < COLS * (ROWS - 1); i++) screen_mem[i] = screen_mem[i + COLS];
      end
    end else if (model_col == COLS - 1 && model_row == ROWS - 1) begin
      for (i = 0; i < CELLS - 1; i++) screen_mem[i] = screen_mem[i + 1];
      screen_mem[CELLS - 1] = c;
    end else begin
      screen_mem[model_row * COLS + model_col] = c;
      if (model_col == COLS - 1) begin
        model_col = '0;
        model_row = model_row + 4'd1;
      end else begin
        model_col = model_col + 3'd1;
      end
    end
  endtask

  task automatic apply_word(input logic [2:0] act, input logic [7:0] c, input logic [7:0] x,
                            input logic [7:0] y, input logic [7:0] clr,
                            output console_reply_t r);
    logic in_range;
    in_range = (x < COLS) && (y < ROWS);
    r = '0;
    case (act)
      ACT_STREAM: begin
        stream_char(c);
        r.ch = c;
      end
      ACT_PUT: begin
        if (c > CODE_MAX || !in_range) r.rejected = 1'b1;
        else screen_mem[y * COLS + x] = c;
      end
      ACT_SETCUR: begin
        if (!in_range) begin
          r.rejected = 1'b1;
        end else begin
          model_col = x[2:0];
          model_row = y[3:0];
        end
      end
      ACT_SETCOL: begin
        if (y >= ROWS || clr > COLOUR_MAX) r.rejected = 1'b1;
        else row_tint[y] = clr[5:0];
      end
      ACT_READ: begin
        if (!in_range) begin
          r.rejected = 1'b1;
        end else begin
          r.ch   = screen_mem[y * COLS + x];
          r.tint = row_tint[y];
        end
      end
      default: r.rejected = 1'b1;
    endcase
    r.cx = model_col;
    r.cy = model_row;
  endtask

  always @(posedge clk) begin
    console_reply_t got;
    console_reply_t want;
    int i;
    if (rst) begin
      for (i = 0; i < CELLS; i++) screen_mem[i] = CODE_SPACE;
      for (i = 0; i < ROWS; i++) row_tint[i] = '0;
      model_col = '0;
      model_row = '0;
      replies_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{status, cell_char, cell_colour, cur_col, cur_row};
        if (replies_due.size() == 0) begin
          $display("%0t: reply with none expected: status %0d char %h colour %0d cursor %0d,%0d",
                   $time, got.rejected, got.ch, got.tint, got.cx, got.cy);
          fail_total++;
        end else begin
          want = replies_due.pop_front();
          if (got !== want) begin
            $display("%0t: reply mismatch: expected status %0d char %h colour %0d cursor %0d,%0d",
                     $time, want.rejected, want.ch, want.tint, want.cx, want.cy);
            $display("%0t:                 actual   status %0d char %h colour %0d cursor %0d,%0d",
                     $time, got.rejected, got.ch, got.tint, got.cx, got.cy);
            fail_total++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_word(action, char_code, col, row, colour, want);
        replies_due.push_back(want);
      end
    end
    pending <= replies_due.size();
    errors  <= fail_total;
  end

endmodule
`default_nettype wire

FILE: tb/text_console_writer_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Drives the text console writer with a directed list of corner words
// (controls, scroll, final-cell shift, range rejects, unknown actions) and
// then a random mix weighted toward streams near the screen end, with random
// gaps on both channels. The checker beside the block judges every reply.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int COLS = COLS_DEF;
  localparam int ROWS = ROWS_DEF;
  localparam int RANDOM_WORDS = 800;
  localparam logic [2:0] ACT_UNUSED_FIRST = ACT_READ + 3'd1;
  localparam logic [2:0] ACT_UNUSED_LAST  = '1;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] action;
  logic [7:0] char_code;
  logic [7:0] col;
  logic [7:0] row;
  logic [7:0] colour;
  logic       out_valid;
  logic       out_ready;
  logic       status;
  logic [7:0] cell_char;
  logic [5:0] cell_colour;
  logic [2:0] cur_col;
  logic [3:0] cur_row;
  int         fail_count;
  int         open_words;
  bit         calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_console_writer #(.COLS(COLS), .ROWS(ROWS)) u_top (
    .clk, .rst, .in_valid, .in_ready, .action, .char_code, .col, .row, .colour,
    .out_valid, .out_ready, .status, .cell_char, .cell_colour, .cur_col, .cur_row
  );

  console_result_checker #(.COLS(COLS), .ROWS(ROWS)) u_check (
    .clk, .rst, .in_valid, .in_ready, .action, .char_code, .col, .row, .colour,
    .out_valid, .out_ready, .status, .cell_char, .cell_colour, .cur_col, .cur_row,
    .errors(fail_count), .pending(open_words)
  );

  // mostly short gaps, a few long ones, none at all in a calm stretch
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic [2:0] act, input logic [7:0] c, input logic [7:0] x,
                           input logic [7:0] y, input logic [7:0] clr);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    char_code <= c;
    col       <= x;
    row       <= y;
    colour    <= clr;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    int         n;
    int         pick;
    logic [2:0] act;
    logic [7:0] c;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] clr;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    action    <= ACT_STREAM;
    char_code <= '0;
    col       <= '0;
    row       <= '0;
    colour    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // corners of a freshly cleared screen
    send_word(ACT_READ, 8'h00, 8'd0, 8'd0, 8'h00);
    send_word(ACT_READ, 8'hFF, 8'(COLS - 1), 8'(ROWS - 1), 8'hFF);
    send_word(ACT_SETCOL, 8'h00, 8'd0, 8'd0, COLOUR_MAX);
    send_word(ACT_SETCOL, 8'h00, 8'd0, 8'(ROWS - 1), 8'h2A);
    send_word(ACT_SETCOL, 8'h00, 8'd0, 8'(ROWS), 8'h01);
    send_word(ACT_SETCOL, 8'h00, 8'd0, 8'd1, COLOUR_MAX + 8'd1);
    send_word(ACT_SETCOL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(ACT_STREAM, 8'h41, 8'hFF, 8'hFF, 8'hFF);
    send_word(ACT_STREAM, CODE_CR, 8'd0, 8'd0, 8'd0);
    send_word(ACT_STREAM, CODE_NL, 8'd0, 8'd0, 8'd0);
    // end of row wraps to the next row
    send_word(ACT_SETCUR, 8'h00, 8'(COLS - 1), 8'd0, 8'h00);
    send_word(ACT_STREAM, 8'hFF, 8'd0, 8'd0, 8'd0);
    send_word(ACT_SETCUR, 8'h00, 8'(COLS), 8'd0, 8'h00);
    send_word(ACT_SETCUR, 8'h00, 8'd0, 8'(ROWS), 8'h00);
    send_word(ACT_SETCUR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(ACT_PUT, CODE_MAX, 8'(COLS - 1), 8'(ROWS - 1), 8'h00);
    send_word(ACT_PUT, CODE_MAX + 8'd1, 8'd0, 8'd0, 8'h00);
    send_word(ACT_PUT, 8'h00, 8'(COLS), 8'd0, 8'h00);
    send_word(ACT_PUT, 8'h00, 8'd0, 8'(ROWS), 8'h00);
    // newline on the last row scrolls, a stream put at the final cell shifts
    send_word(ACT_SETCUR, 8'h00, 8'd3, 8'(ROWS - 1), 8'h00);
    send_word(ACT_STREAM, CODE_NL, 8'd0, 8'd0, 8'd0);
    send_word(ACT_SETCUR, 8'h00, 8'(COLS - 1), 8'(ROWS - 1), 8'h00);
    send_word(ACT_STREAM, 8'h5A, 8'd0, 8'd0, 8'd0);
    send_word(ACT_READ, 8'h00, 8'(COLS), 8'd0, 8'h00);
    send_word(ACT_READ, 8'h00, 8'd0, 8'(ROWS), 8'h00);
    send_word(ACT_UNUSED_FIRST, 8'h00, 8'd0, 8'd0, 8'h00);
    send_word(ACT_UNUSED_LAST, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(ACT_READ, 8'h00, 8'(COLS - 2), 8'(ROWS - 1), 8'h00);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      c    = 8'($urandom);
      x    = 8'($urandom);
      y    = 8'($urandom);
      clr  = 8'($urandom);
      if (pick < 45) begin
        act = ACT_STREAM;
        case ($urandom_range(0, 9))
          0: c = CODE_CR;
          1: c = CODE_NL;
          default: ;
        endcase
      end else if (pick < 57) begin
        // lean toward the last row and column so scrolls and shifts happen
        act = ACT_SETCUR;
        if ($urandom_range(0, 9) < 8) begin
          x = $urandom_range(0, 1) ? 8'(COLS - 1) : 8'($urandom_range(0, COLS - 1));
          y = $urandom_range(0, 1) ? 8'(ROWS - 1) : 8'($urandom_range(0, ROWS - 1));
        end
      end else if (pick < 67) begin
        act = ACT_PUT;
        if ($urandom_range(0, 9) < 8) begin
          c = 8'($urandom_range(0, CODE_MAX));
          x = 8'($urandom_range(0, COLS - 1));
          y = 8'($urandom_range(0, ROWS - 1));
        end
      end else if (pick < 75) begin
        act = ACT_SETCOL;
        if ($urandom_range(0, 9) < 8) y = 8'($urandom_range(0, ROWS - 1));
        if ($urandom_range(0, 9) < 8) clr = 8'($urandom_range(0, COLOUR_MAX));
      end else if (pick < 95) begin
        act = ACT_READ;
        if ($urandom_range(0, 9) < 9) begin
          x = 8'($urandom_range(0, COLS - 1));
          y = 8'($urandom_range(0, ROWS - 1));
        end
      end else if (pick < 97) begin
        act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
      end else begin
        act = 3'($urandom);
      end
      send_word(act, c, x, y, clr);
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    do @(posedge clk); while (open_words != 0);
    repeat (COLS * ROWS + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("text_console_writer_tb: done, clean");
    end else begin
      $display("text_console_writer_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("text_console_writer_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
design/tcw_pkg.sv
design/tcw_ram.sv
design/text_console_writer.sv
tb/console_result_checker.sv
tb/text_console_writer_tb.sv
